/* hw/rtl/sobel_edge_magnitude_3x3_defines.svh */
// ----------------------------------------------------------------------------
// Sobel edge magnitude assertion macros
// Shared property forms for the checks at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define SOBM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sobm_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared constants, register indexes and the front-to-back flag bundle.
// ----------------------------------------------------------------------------
package sobm_pkg;

  localparam int MAX_WIDTH_DEFAULT   = 2048;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

  localparam logic [16:0] IN_ROW_MAX = 17'h1FFFF;
  localparam logic [7:0]  MAG_MAX    = 8'd255;
  localparam logic [20:0] SAT_LIMIT  = 21'd65025;   // 255 squared

  // per-item classification made by the front end
  typedef struct packed {
    logic emit;         // item releases a result
    logic first_col;    // input column is zero: newest column is off the image
    logic mask_left;    // result pixel sits on the left border
    logic mask_right;   // result pixel sits on the right border
    logic mask_top;     // result pixel sits on the top row
    logic mask_bottom;  // result pixel sits on the bottom row
    logic last;         // result is the final pixel of the frame
  } flags_t;

endpackage

/* hw/rtl/sobel_edge_magnitude_3x3.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3, streaming
// Takes the gray pixels of a frame in raster order (tuser low) and returns
// floor(sqrt(Gx^2 + Gy^2)) saturated at 255 for each pixel, with neighbours
// outside the image taken as zero. A result lags its pixel by one line plus
// one pixel, so after the frame send image_width+1 flush transactions
// (tuser high); the final pixel carries tlast and the next transaction starts
// a new frame. The block sustains one transaction per clock on both sides:
// a front end classifies each item in its accepting cycle, a queue of
// QUEUE_DEPTH entries decouples it from a back end that reads the line store
// (one read and one write port, bypassed when they meet), forms the
// gradients, squares and takes the root in five register stages. Output back
// pressure freezes the back end; input tready drops only once the queue is
// full. Write image_width and image_height only between frames with the
// block drained. The line store needs no clearing pass: entries not yet
// written only reach border neighbours that are forced to zero.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 #(
  parameter int MAX_WIDTH   = sobm_pkg::MAX_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = sobm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // gray[7:0]
  input  logic        s_axis_tuser,    // cmd: 0 pixel, 1 flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // magnitude[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int FW = $bits(sobm_pkg::flags_t);
  localparam int QW = IW + 8 + FW;

  logic [11:0]      image_width;
  logic [15:0]      image_height;

  logic             accept;
  logic [7:0]       f_pix;
  logic [IW-1:0]    f_idx;
  sobm_pkg::flags_t f_flags;

  logic             q_full;
  logic             q_not_empty;
  logic             q_pop;
  logic [QW-1:0]    q_rdata;
  sobm_pkg::flags_t q_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sobm_pkg::IMAGE_WIDTH_RESET;
      image_height <= sobm_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        sobm_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        sobm_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sobm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (s_axis_tuser),
    .gray         (s_axis_tdata),
    .image_width  (image_width),
    .image_height (image_height),
    .pix          (f_pix),
    .idx          (f_idx),
    .flags        (f_flags)
  );

  sobm_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .wdata     ({f_idx, f_pix, f_flags}),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  assign q_flags = q_rdata[FW-1:0];

  sobm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_not_empty),
    .q_pix         (q_rdata[FW +: 8]),
    .q_idx         (q_rdata[FW+8 +: IW]),
    .q_flags       (q_flags),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hw/rtl/sobm_queue.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude queue
// Small flop FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_3x3_defines.svh"

module sobm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sobm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign not_empty = (count != '0);
  assign full      = (count == CNTW'(DEPTH));
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

  `SOBM_ASSERT(a_no_overrun, push, !full || pop, "queue pushed while full")
  `SOBM_ASSERT(a_no_underrun, pop, not_empty, "queue popped while empty")

endmodule

/* hw/rtl/sobm_front.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude front end
// Tracks input and output positions, gates the pixel and classifies each item.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_3x3_defines.svh"

module sobm_front #(
  parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         cmd,
  input  logic [7:0]                   gray,
  input  logic [11:0]                  image_width,
  input  logic [15:0]                  image_height,
  output logic [7:0]                   pix,
  output logic [$clog2(MAX_WIDTH)-1:0] idx,
  output sobm_pkg::flags_t             flags
);

  localparam int IW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [IW-1:0] in_column;
  logic [16:0]   in_row;
  logic [IW-1:0] out_column;
  logic [15:0]   out_row;

  logic [CW-1:0] w_used;
  logic [15:0]   h_used;
  logic          ic_end;
  logic          oc_end;
  logic          orow_end;
  logic          in_frame;
  logic          emit;
  logic          last;

  always_comb begin
    if (image_width == '0) begin
      w_used = CW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_used = CW'(MAX_WIDTH);
    end else begin
      w_used = CW'(image_width);
    end
    h_used   = (image_height == '0) ? 16'd1 : image_height;
    ic_end   = (CW'(in_column) + CW'(1)) >= w_used;
    oc_end   = (CW'(out_column) + CW'(1)) >= w_used;
    orow_end = (17'(out_row) + 17'd1) >= 17'(h_used);
    in_frame = in_row < 17'(h_used);
    emit     = (in_row >= 17'd2) || ((in_row == 17'd1) && (in_column != '0));
    last     = emit && orow_end && oc_end;
  end

  // a flush inside the frame and any item past the frame carry a zero pixel
  assign pix = (!cmd && in_frame) ? gray : 8'd0;
  assign idx = in_column;

  always_comb begin
    flags.emit        = emit;
    flags.first_col   = (in_column == '0);
    flags.mask_left   = (out_column == '0);
    flags.mask_right  = oc_end;
    flags.mask_top    = (out_row == '0);
    flags.mask_bottom = orow_end;
    flags.last        = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      if (last) begin
        // frame done: rewind every position
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (emit) begin
          if (oc_end) begin
            out_column <= '0;
            out_row    <= out_row + 16'd1;
          end else begin
            out_column <= out_column + IW'(1);
          end
        end
        if (ic_end) begin
          in_column <= '0;
          if (in_row != sobm_pkg::IN_ROW_MAX) begin
            in_row <= in_row + 17'd1;
          end
        end else begin
          in_column <= in_column + IW'(1);
        end
      end
    end
  end

  `SOBM_ASSERT(a_last_emits, accept && flags.last, flags.emit, "last without a result")
  `SOBM_ASSERT_NEXT(a_last_rewinds, accept && flags.last,
    in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0,
    "positions not rewound after last")

endmodule

/* hw/rtl/sobm_back.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude back end
// Line stores, 3x3 window, gradients, magnitude and the output register.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_3x3_defines.svh"

module sobm_back #(
  parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic [7:0]                   q_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_idx,
  input  sobm_pkg::flags_t             q_flags,
  output logic                         pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // magnitude[7:0]
  output logic                         m_axis_tlast
);

  localparam int IW = $clog2(MAX_WIDTH);

  // one half of a floor square root: four root bits from four bit pairs,
  // continuing from the remainder and partial root of the upper half
  function automatic logic [18:0] sqrt_half(input logic [10:0] rem_in,
                                            input logic [7:0]  root_in,
                                            input logic [7:0]  pairs);
    logic [10:0] rem;
    logic [10:0] cur;
    logic [10:0] trial;
    logic [7:0]  root;
    rem  = rem_in;
    root = root_in;
    for (int i = 3; i >= 0; i--) begin
      cur   = {rem[8:0], pairs[2*i +: 2]};
      trial = {1'b0, root, 2'b01};
      if (cur >= trial) begin
        rem  = cur - trial;
        root = {root[6:0], 1'b1};
      end else begin
        rem  = cur;
        root = {root[6:0], 1'b0};
      end
    end
    return {rem, root};
  endfunction

  // both line stores share one word: {two lines up, one line up}
  logic [15:0] line_mem [MAX_WIDTH];
  logic [15:0] rdata;
  logic        fwd;
  logic [15:0] fwd_word;

  logic                adv;
  logic                b_valid;
  logic [7:0]          b_pix;
  logic [IW-1:0]       b_idx;
  sobm_pkg::flags_t    b_flags;

  logic [2:0][7:0]     win_a;     // older column
  logic [2:0][7:0]     win_b;     // newer column
  logic [15:0]         line_word;
  logic [15:0]         wr_word;
  logic [2:0][7:0]     col_new;
  logic [2:0][2:0][7:0] nb;       // [row][col], col 0 = left
  logic [9:0]          sum_l;
  logic [9:0]          sum_r;
  logic [9:0]          sum_t;
  logic [9:0]          sum_d;
  logic signed [10:0]  gx;
  logic signed [10:0]  gy;

  logic                c_valid;
  logic                c_last;
  logic signed [10:0]  c_gx;
  logic signed [10:0]  c_gy;
  logic signed [21:0]  sqx;
  logic signed [21:0]  sqy;
  logic [20:0]         sq_sum;

  logic                d_valid;
  logic                d_last;
  logic                d_sat;
  logic [15:0]         d_sum;

  logic                e_valid;
  logic                e_last;
  logic                e_sat;
  logic [10:0]         e_rem;
  logic [7:0]          e_root;
  logic [7:0]          e_low;
  logic [18:0]         hi_step;
  logic [18:0]         lo_step;

  // the whole pipe moves together and freezes while the output is held
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign pop = adv && q_valid;

  assign line_word = fwd ? fwd_word : rdata;
  assign wr_word   = {line_word[7:0], b_pix};
  assign col_new   = {b_pix, line_word[7:0], line_word[15:8]};

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= line_mem[q_idx];
    end
    if (adv && b_valid) begin
      line_mem[b_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pix    <= q_pix;
      b_idx    <= q_idx;
      b_flags  <= q_flags;
      fwd_word <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd     <= 1'b0;
      win_a   <= '0;
      win_b   <= '0;
    end else if (adv) begin
      b_valid <= pop;
      // a read that meets the write of the same entry takes the new word
      fwd     <= pop && b_valid && (b_idx == q_idx);
      if (b_valid) begin
        win_a <= win_b;
        win_b <= col_new;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = b_flags.mask_left ? 8'd0 : win_a[r];
      nb[r][1] = win_b[r];
      nb[r][2] = (b_flags.first_col || b_flags.mask_right) ? 8'd0 : col_new[r];
    end
    if (b_flags.mask_top) begin
      nb[0] = '0;
    end
    if (b_flags.mask_bottom) begin
      nb[2] = '0;
    end
    sum_r = 10'(nb[0][2]) + 10'({nb[1][2], 1'b0}) + 10'(nb[2][2]);
    sum_l = 10'(nb[0][0]) + 10'({nb[1][0], 1'b0}) + 10'(nb[2][0]);
    sum_d = 10'(nb[2][0]) + 10'({nb[2][1], 1'b0}) + 10'(nb[2][2]);
    sum_t = 10'(nb[0][0]) + 10'({nb[0][1], 1'b0}) + 10'(nb[0][2]);
    gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy    = $signed({1'b0, sum_d}) - $signed({1'b0, sum_t});
  end

  always_comb begin
    sqx    = c_gx * c_gx;
    sqy    = c_gy * c_gy;
    sq_sum = 21'(sqx) + 21'(sqy);
  end

  // root split over two stages: upper four bits, then lower four bits
  always_comb begin
    hi_step = sqrt_half(11'd0, 8'd0, d_sum[15:8]);
    lo_step = sqrt_half(e_rem, e_root, e_low);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_gx   <= gx;
      c_gy   <= gy;
      c_last <= b_flags.last;
      d_sat  <= (sq_sum >= sobm_pkg::SAT_LIMIT);
      d_sum  <= sq_sum[15:0];
      d_last <= c_last;
      e_sat  <= d_sat;
      e_rem  <= hi_step[18:8];
      e_root <= hi_step[7:0];
      e_low  <= d_sum[7:0];
      e_last <= d_last;
      m_axis_tdata <= e_sat ? sobm_pkg::MAG_MAX : lo_step[7:0];
      m_axis_tlast <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid       <= 1'b0;
      d_valid       <= 1'b0;
      e_valid       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      c_valid       <= b_valid && b_flags.emit;
      d_valid       <= c_valid;
      e_valid       <= d_valid;
      m_axis_tvalid <= e_valid;
    end
  end

  `SOBM_ASSERT(a_fwd_has_item, fwd, b_valid, "bypass word set with no item in the read stage")

endmodule

/* bench/sobel_magnitude_checker.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Watches the pixel, result and register channels of the edge magnitude block.
// A line-buffered copy of the 3x3 Sobel datapath predicts each result. Every
// result transaction is compared in order against the oldest prediction.
// ----------------------------------------------------------------------------
module sobel_magnitude_checker #(
  parameter int MAX_WIDTH = sobm_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // gray[7:0]
  input  logic        s_axis_tuser,    // cmd: 0 pixel, 1 flush
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,    // magnitude[7:0]
  input  logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          results_pending
);

  typedef struct packed {
    logic [7:0] magnitude;
    logic       last;
  } edge_result_t;

  logic [11:0]  width_reg;
  logic [15:0]  height_reg;
  logic [7:0]   row_above [MAX_WIDTH];
  logic [7:0]   row_above2 [MAX_WIDTH];
  logic [7:0]   win [3][3];    // [top..bottom][oldest..newest column]
  int unsigned  in_col;
  int unsigned  in_line;
  int unsigned  out_col;
  int unsigned  out_line;
  edge_result_t expected_pixels [$];
  int           mismatches;

  // floor of the square root, clipped to one byte
  function automatic logic [7:0] edge_magnitude(input int unsigned energy);
    int unsigned root;
    int unsigned trial;
    root = 0;
    if (energy >= sobm_pkg::SAT_LIMIT) return sobm_pkg::MAG_MAX;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= energy) root = trial;
    end
    return root[7:0];
  endfunction

  task automatic advance_window(input logic flush, input logic [7:0] level);
    int unsigned  w;
    int unsigned  h;
    int unsigned  col;
    int unsigned  slot;
    logic [7:0]   pix;
    logic [7:0]   held [3][3];
    int           nb [3][3];
    int           gx;
    int           gy;
    bit           produce;
    bit           at_end;
    edge_result_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    col = in_col;
    slot = (col < MAX_WIDTH) ? col : 0;
    // flush inside the frame and pixels past it both enter as zero
    pix = (!flush && in_line < h) ? level : 8'd0;
    held = win;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = row_above2[slot];
    win[1][2] = row_above[slot];
    win[2][2] = pix;
    row_above2[slot] = row_above[slot];
    row_above[slot] = pix;

    produce = (in_line >= 2) || (in_line == 1 && col >= 1);
    at_end = 1'b0;
    if (produce) begin
      for (int r = 0; r < 3; r++) begin
        if (col >= 1) begin
          for (int c = 0; c < 3; c++) nb[r][c] = win[r][c];
        end else begin
          // newest column wrapped to the next line: result pixel is on the right edge
          nb[r][0] = held[r][1];
          nb[r][1] = held[r][2];
          nb[r][2] = 0;
        end
        if (out_col < 1) nb[r][0] = 0;
        if (out_col + 1 >= w) nb[r][2] = 0;
      end
      if (out_line < 1) for (int c = 0; c < 3; c++) nb[0][c] = 0;
      if (out_line + 1 >= h) for (int c = 0; c < 3; c++) nb[2][c] = 0;

      gx = (nb[0][2] + 2 * nb[1][2] + nb[2][2]) - (nb[0][0] + 2 * nb[1][0] + nb[2][0]);
      gy = (nb[2][0] + 2 * nb[2][1] + nb[2][2]) - (nb[0][0] + 2 * nb[0][1] + nb[0][2]);
      res.magnitude = edge_magnitude(gx * gx + gy * gy);

      if (out_line + 1 >= h && out_col + 1 >= w) begin
        at_end = 1'b1;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_line = (out_line + 1) & 32'hFFFF;
      end else begin
        out_col++;
      end
      res.last = at_end;
      expected_pixels.push_back(res);
    end

    if (at_end) begin
      in_col = 0;
      in_line = 0;
      out_col = 0;
      out_line = 0;
    end else if (col + 1 >= w) begin
      in_col = 0;
      if (in_line < sobm_pkg::IN_ROW_MAX) in_line++;
    end else begin
      in_col++;
    end
  endtask

  always @(posedge clk) begin
    edge_result_t want;
    if (rst) begin
      width_reg = sobm_pkg::IMAGE_WIDTH_RESET;
      height_reg = sobm_pkg::IMAGE_HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = 8'd0;
        row_above2[i] = 8'd0;
      end
      win = '{default: 8'd0};
      in_col = 0;
      in_line = 0;
      out_col = 0;
      out_line = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == sobm_pkg::CFG_IMAGE_WIDTH) width_reg = cfg_data[11:0];
        else height_reg = cfg_data;
      end
      if (s_axis_tvalid && s_axis_tready) advance_window(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: magnitude %0d, last %0b", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata !== want.magnitude) begin
            $error("magnitude mismatch: expected %0d, got %0d", want.magnitude, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, m_axis_tlast);
            mismatches++;
          end
        end
      end
    end
    results_pending <= expected_pixels.size();
    fail_count <= mismatches;
  end

endmodule

/* bench/sobel_edge_magnitude_3x3_test.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams gray frames of many sizes through the block: a directed set of
// border and saturation frames, then random frames with in-frame flushes,
// pixels in the drain phase and undrained pauses. The sender idles in
// bursts, the receiver stalls on its own pattern, and the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_test;

  localparam int       MAX_WIDTH   = sobm_pkg::MAX_WIDTH_DEFAULT;
  localparam int       PIPE_SETTLE = 64;
  localparam int       RANDOM_ITEMS = 850;
  localparam logic     CMD_PIXEL = 1'b0;
  localparam logic     CMD_FLUSH = 1'b1;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;    // gray[7:0]
  logic        s_axis_tuser = 1'b0;    // cmd: 0 pixel, 1 flush
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // magnitude[7:0]
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_data = 16'd0;

  int          fail_count;
  int          results_pending;
  int          burst_left = 0;
  int          gap_mode = 0;
  int          items_sent = 0;
  logic [31:0] ready_pattern = '1;
  int          ready_phase = 0;

  sobel_edge_magnitude_3x3 DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  sobel_magnitude_checker #(.MAX_WIDTH(MAX_WIDTH)) scoreboard (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: reload a 32-bit ready pattern of a random density
  always @(posedge clk) begin
    if (ready_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = '1;
        1:       ready_pattern = $urandom;
        2:       ready_pattern = $urandom & $urandom;
        default: ready_pattern = $urandom | $urandom;
      endcase
    end
    m_axis_tready <= ready_pattern[ready_phase];
    ready_phase = (ready_phase + 1) % 32;
  end

  task automatic drive_transaction(input logic cmd, input logic [7:0] level);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_mode != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, (gap_mode == 1) ? 3 : 12)) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= level;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // hold off until every predicted result is out and the pipeline has emptied
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] width, input logic [15:0] height);
    cfg_we <= 1'b1;
    cfg_addr <= sobm_pkg::CFG_IMAGE_WIDTH;
    cfg_data <= {4'd0, width};
    @(posedge clk);
    cfg_addr <= sobm_pkg::CFG_IMAGE_HEIGHT;
    cfg_data <= height;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // whole frames plus their drain, so the block ends each call between frames
  task automatic run_frames(input logic [11:0] width, input logic [15:0] height,
                            input int frames, input bit allow_pause);
    int   wu;
    int   hu;
    int   pixels;
    int   style;
    int   level;
    bit   pause_here;
    logic cmd;
    wu = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
    hu = (height == 0) ? 1 : height;
    pixels = wu * hu;
    for (int f = 0; f < frames; f++) begin
      style = $urandom_range(0, 2);
      level = $urandom_range(0, 255);
      pause_here = allow_pause && ($urandom_range(0, 5) == 0);
      for (int p = 0; p < pixels + wu + 1; p++) begin
        // leave the last row undrained for a while
        if (pause_here && p == pixels) quiesce();
        if (p < pixels) cmd = ($urandom_range(0, 31) == 0) ? CMD_FLUSH : CMD_PIXEL;
        else cmd = ($urandom_range(0, 15) == 0) ? CMD_PIXEL : CMD_FLUSH;
        case (style)
          0: level = $urandom_range(0, 255);
          1: level = $urandom_range(0, 1) ? 255 : 0;
          default: begin
            level = level + int'($urandom_range(0, 16)) - 8;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
          end
        endcase
        drive_transaction(cmd, level[7:0]);
      end
    end
  endtask

  initial begin
    int w;
    int h;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 3x3 with saturating edges, a flush in the frame and a pixel in the drain
    configure(12'd3, 16'd3);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_PIXEL, 8'd0);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_PIXEL, 8'd0);
    drive_transaction(CMD_FLUSH, 8'd255);
    drive_transaction(CMD_PIXEL, 8'd0);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_PIXEL, 8'd0);
    quiesce();
    drive_transaction(CMD_FLUSH, 8'd0);
    drive_transaction(CMD_PIXEL, 8'd128);
    drive_transaction(CMD_FLUSH, 8'd255);
    drive_transaction(CMD_FLUSH, 8'd0);
    quiesce();

    // zero sizes run as a single pixel
    configure(12'd0, 16'd0);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_FLUSH, 8'd0);
    drive_transaction(CMD_FLUSH, 8'd0);
    quiesce();

    // one row of two
    configure(12'd2, 16'd1);
    drive_transaction(CMD_PIXEL, 8'd0);
    drive_transaction(CMD_PIXEL, 8'd255);
    drive_transaction(CMD_FLUSH, 8'd0);
    drive_transaction(CMD_FLUSH, 8'd0);
    drive_transaction(CMD_FLUSH, 8'd0);
    quiesce();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      gap_mode = $urandom_range(0, 2);
      configure(w[11:0], h[15:0]);
      run_frames(w[11:0], h[15:0], $urandom_range(1, 3), 1'b1);
      quiesce();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sobm_pkg.sv
hw/rtl/sobm_queue.sv
hw/rtl/sobm_front.sv
hw/rtl/sobm_back.sv
hw/rtl/sobel_edge_magnitude_3x3.sv
bench/sobel_magnitude_checker.sv
bench/sobel_edge_magnitude_3x3_test.sv
